/* sv/assert_macros.svh */
// Assertion macros used by the deframer checker.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define RFD_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("deframer check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define RFD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("deframer check failed");

`endif

/* sv/rfd_pkg.sv */
// ----------------------------------------------------------------------------
// Radio frame deframer package
// Shared types, codes and sizes of the deframer core and its result queue.
// ----------------------------------------------------------------------------
package rfd_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned HeaderLen  = 11;
  localparam int unsigned HdrCntW    = 4;
  localparam int unsigned CfgIdxW    = 1;

  localparam int unsigned FifoDepth  = 4;
  localparam int unsigned FifoPtrW   = $clog2(FifoDepth);
  localparam int unsigned FifoCntW   = $clog2(FifoDepth + 1);

  localparam logic [CfgIdxW-1:0] RegStartSymbol = 1'b0;
  localparam logic [CfgIdxW-1:0] RegStopSymbol  = 1'b1;

  localparam logic [ByteW-1:0] StartSymbolReset = 8'd2;
  localparam logic [ByteW-1:0] StopSymbolReset  = 8'd3;

  typedef enum logic [1:0] {
    KindHeader  = 2'd0,
    KindContent = 2'd1,
    KindStatus  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusNoStart  = 2'd1,
    StatusMismatch = 2'd2
  } status_e;

  typedef struct packed {
    kind_e            kind;
    logic [ByteW-1:0] position;
    logic [ByteW-1:0] value;
    status_e          status;
    logic             last;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

/* sv/rfd_core.sv */
// ----------------------------------------------------------------------------
// Deframer core
// Holds the frame phase, counters and symbol registers, and turns each
// accepted byte into zero, one or two result beats for the queue.
// ----------------------------------------------------------------------------
module rfd_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  logic [rfd_pkg::ByteW-1:0]   rx_byte_i,
  input  logic                        packet_end_i,
  input  logic                        cfg_write_i,
  input  logic [rfd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [rfd_pkg::ByteW-1:0]   cfg_data_i,
  output rfd_pkg::push_t              push_o
);

  typedef enum logic [2:0] {
    PhStart   = 3'd0,
    PhHeader  = 3'd1,
    PhContent = 3'd2,
    PhStop    = 3'd3,
    PhDrop    = 3'd4
  } phase_e;

  phase_e                      phase_q, phase_d;
  logic [rfd_pkg::HdrCntW-1:0] hdr_cnt_q, hdr_cnt_d;
  logic [rfd_pkg::ByteW-1:0]   left_q, left_d;
  logic [rfd_pkg::ByteW-1:0]   offset_q, offset_d;
  logic [rfd_pkg::ByteW-1:0]   open_code_q, close_code_q;

  rfd_pkg::result_t res0, res1;
  logic [1:0]       n_res;
  logic             status_given;

  always_comb begin
    phase_d      = phase_q;
    hdr_cnt_d    = hdr_cnt_q;
    left_d       = left_q;
    offset_d     = offset_q;
    res0         = '0;
    res1         = '0;
    n_res        = 2'd0;
    status_given = 1'b0;

    case (phase_q)
      PhStart: begin
        if (rx_byte_i == open_code_q) begin
          phase_d   = PhHeader;
          hdr_cnt_d = '0;
          left_d    = '0;
          offset_d  = '0;
        end else begin
          res0.kind    = rfd_pkg::KindStatus;
          res0.status  = rfd_pkg::StatusNoStart;
          n_res        = 2'd1;
          status_given = 1'b1;
          phase_d      = PhDrop;
        end
      end
      PhHeader: begin
        res0.kind     = rfd_pkg::KindHeader;
        res0.position = {{(rfd_pkg::ByteW - rfd_pkg::HdrCntW){1'b0}}, hdr_cnt_q};
        res0.value    = rx_byte_i;
        n_res         = 2'd1;
        if (hdr_cnt_q >= rfd_pkg::HdrCntW'(rfd_pkg::HeaderLen - 1)) begin
          left_d   = rx_byte_i;
          offset_d = '0;
          phase_d  = (rx_byte_i == '0) ? PhStop : PhContent;
        end else begin
          hdr_cnt_d = hdr_cnt_q + 1'b1;
        end
      end
      PhContent: begin
        res0.kind     = rfd_pkg::KindContent;
        res0.position = offset_q;
        res0.value    = rx_byte_i;
        n_res         = 2'd1;
        offset_d      = offset_q + 1'b1;
        left_d        = left_q - 1'b1;
        if (left_d == '0) begin
          phase_d = PhStop;
        end
      end
      PhStop: begin
        res0.kind    = rfd_pkg::KindStatus;
        res0.status  = (rx_byte_i == close_code_q) ? rfd_pkg::StatusOk
                                                   : rfd_pkg::StatusMismatch;
        n_res        = 2'd1;
        status_given = 1'b1;
        phase_d      = PhDrop;
      end
      default: begin
        status_given = 1'b1;
        phase_d      = PhDrop;
      end
    endcase

    if (packet_end_i) begin
      if (!status_given) begin
        if (n_res == 2'd0) begin
          res0.kind   = rfd_pkg::KindStatus;
          res0.status = rfd_pkg::StatusMismatch;
          n_res       = 2'd1;
        end else begin
          res1.kind   = rfd_pkg::KindStatus;
          res1.status = rfd_pkg::StatusMismatch;
          n_res       = 2'd2;
        end
      end
      phase_d   = PhStart;
      hdr_cnt_d = '0;
      left_d    = '0;
      offset_d  = '0;
    end

    res0.last = (n_res == 2'd1);
    res1.last = (n_res == 2'd2);
  end

  always_comb begin
    push_o.count = accept_i ? n_res : 2'd0;
    push_o.r0    = res0;
    push_o.r1    = res1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhStart;
      hdr_cnt_q    <= '0;
      left_q       <= '0;
      offset_q     <= '0;
      open_code_q  <= rfd_pkg::StartSymbolReset;
      close_code_q <= rfd_pkg::StopSymbolReset;
    end else begin
      if (accept_i) begin
        phase_q   <= phase_d;
        hdr_cnt_q <= hdr_cnt_d;
        left_q    <= left_d;
        offset_q  <= offset_d;
      end
      if (cfg_write_i && (cfg_index_i == rfd_pkg::RegStartSymbol)) begin
        open_code_q <= cfg_data_i;
      end
      if (cfg_write_i && (cfg_index_i == rfd_pkg::RegStopSymbol)) begin
        close_code_q <= cfg_data_i;
      end
    end
  end

endmodule

/* sv/rfd_fifo.sv */
// ----------------------------------------------------------------------------
// Deframer result queue
// Small register queue that takes up to two result beats per cycle and
// hands out one beat per cycle while the output is not stalled, from a registered entry.
// ----------------------------------------------------------------------------
module rfd_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rfd_pkg::push_t   push_i,
  output logic             room_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output rfd_pkg::result_t out_data_o
);

  rfd_pkg::result_t                mem_q [rfd_pkg::FifoDepth];
  logic [rfd_pkg::FifoPtrW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [rfd_pkg::FifoPtrW-1:0]    wr_ptr_next;
  logic [rfd_pkg::FifoCntW-1:0]    cnt_q;
  logic                            pop;

  assign wr_ptr_next = wr_ptr_q + 1'b1;
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && !out_stall_i;
  assign room_o      = (cnt_q <= rfd_pkg::FifoCntW'(rfd_pkg::FifoDepth - 2));

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.r0;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_ptr_next] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + rfd_pkg::FifoPtrW'(push_i.count);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_q + rfd_pkg::FifoCntW'(push_i.count)
                     - rfd_pkg::FifoCntW'(pop);
    end
  end

endmodule

/* sv/radio_frame_deframer_top.sv */
// The results of a byte are registered in the result queue and offered from its head in order.
// Throughput: one byte per cycle while the queue has room; a byte with two results gives two output beats.
// The input stalls while the four-entry result queue has fewer than two free entries.
// Reset clears phase and counters, empties the queue, and sets the symbols to 2 and 3.
// ----------------------------------------------------------------------------
// Radio frame deframer
// Splits length-prefixed packets into header, content and status results.
// ----------------------------------------------------------------------------
module radio_frame_deframer_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [7:0]                  rx_byte_i,
  input  logic                        packet_end_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  item_kind_o,
  output logic [7:0]                  position_o,
  output logic [7:0]                  byte_value_o,
  output logic [1:0]                  frame_status_o,
  output logic                        last_of_run_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [rfd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]                  cfg_data_i
);

  rfd_pkg::push_t   push;
  rfd_pkg::result_t out_data;
  logic             room;
  logic             accept;

  assign in_stall_o  = !room;
  assign accept      = in_valid_i && room;
  assign cfg_ready_o = 1'b1;

  rfd_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .rx_byte_i    (rx_byte_i),
    .packet_end_i (packet_end_i),
    .cfg_write_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .push_o       (push)
  );

  rfd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data)
  );

  assign item_kind_o    = out_data.kind;
  assign position_o     = out_data.position;
  assign byte_value_o   = out_data.value;
  assign frame_status_o = out_data.status;
  assign last_of_run_o  = out_data.last;

endmodule

/* sv/rfd_checker.sv */
// ----------------------------------------------------------------------------
// Deframer port checker
// Watches the result port of the deframer and flags malformed beats.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rfd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] item_kind_o,
  input logic [7:0] position_o,
  input logic [7:0] byte_value_o,
  input logic [1:0] frame_status_o,
  input logic       last_of_run_o
);

  logic [20:0] out_beat;

  assign out_beat = {item_kind_o, position_o, byte_value_o, frame_status_o, last_of_run_o};

  // A stalled beat stays on the port unchanged.
  `RFD_ASSERT_NEXT(a_stall_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_beat))

  `RFD_ASSERT_IMPL(a_kind_legal, out_valid_o, item_kind_o <= rfd_pkg::KindStatus)

  `RFD_ASSERT_IMPL(a_data_status_zero, out_valid_o && item_kind_o != rfd_pkg::KindStatus, frame_status_o == rfd_pkg::StatusOk)

  `RFD_ASSERT_IMPL(a_status_fields, out_valid_o && item_kind_o == rfd_pkg::KindStatus, position_o == 8'd0 && byte_value_o == 8'd0 && frame_status_o <= rfd_pkg::StatusMismatch && last_of_run_o)

endmodule

bind radio_frame_deframer_top rfd_checker u_rfd_checker (.*);
